@@ src/f32f16_pkg.sv @@
package f32f16_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;

  typedef enum logic {
    FUNC_S2H = 1'b0,
    FUNC_H2S = 1'b1
  } func_e;

  typedef struct packed {
    logic [0:0]       func;
    logic [WordW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] result_bits;
  } out_t;

  localparam logic [WordW-1:0] Sign32    = 32'h8000_0000;
  localparam logic [WordW-1:0] Inf32     = 32'h7F80_0000;
  localparam logic [WordW-1:0] KeepMask  = 32'hFFFF_F000;
  localparam logic [WordW-1:0] HalfInfAt = 32'h0F80_0000;
  localparam logic [HalfW-1:0] HalfNan   = 16'h7FFF;
  localparam logic [HalfW-1:0] HalfInf   = 16'h7C00;

endpackage

@@ src/f32f16_if.sv @@
interface f32f16_in_if;
  logic               valid;
  logic               ready;
  f32f16_pkg::in_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface f32f16_out_if;
  logic               valid;
  logic               ready;
  f32f16_pkg::out_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/f32f16_core.sv @@
module f32f16_core (
  input  logic [0:0]  func_i,
  input  logic [31:0] value_i,
  output logic [31:0] result_o
);

  logic [31:0] sign, mag, kept, scaled, t, m, k, rem, halfway, h2s;
  logic [7:0]  e;
  logic [7:0]  shift;
  logic [15:0] half;
  logic [4:0]  he;
  logic [9:0]  hf;
  logic [3:0]  p;
  logic [31:0] fsh;

  // Single to half: scale by 2^-112 with round to nearest even, then round ties away from zero.
  always_comb begin
    sign    = value_i & f32f16_pkg::Sign32;
    mag     = value_i ^ sign;
    kept    = mag & f32f16_pkg::KeepMask;
    e       = kept[30:23];
    m       = {9'd0, kept[22:0]};
    scaled  = '0;
    shift   = '0;
    k       = '0;
    rem     = '0;
    halfway = '0;
    if (e >= 8'd113) begin
      scaled = kept - (32'd112 << 23);
    end else begin
      if (e != 8'd0) begin
        m[23] = 1'b1;
        shift = 8'd113 - e;
      end else begin
        shift = 8'd112;
      end
      if (shift < 8'd25) begin
        k       = m >> shift[4:0];
        rem     = m & ((32'd1 << shift[4:0]) - 32'd1);
        halfway = 32'd1 << (shift[4:0] - 5'd1);
        if (rem > halfway || (rem == halfway && k[0])) begin
          scaled = k + 32'd1;
        end else begin
          scaled = k;
        end
      end
    end
    t = scaled + 32'h1000;
    if (t > f32f16_pkg::HalfInfAt) begin
      t = f32f16_pkg::HalfInfAt;
    end
    if (mag > f32f16_pkg::Inf32) begin
      half = f32f16_pkg::HalfNan;
    end else if (mag == f32f16_pkg::Inf32) begin
      half = f32f16_pkg::HalfInf;
    end else begin
      half = t[28:13];
    end
    half[15] = half[15] | sign[31];
  end

  // Half to single is exact; subnormals normalize by a leading-one search.
  always_comb begin
    he  = value_i[14:10];
    hf  = value_i[9:0];
    p   = '0;
    for (int i = 0; i < 10; i++) begin
      if (hf[i]) p = 4'(i);
    end
    fsh = {22'd0, hf} << (5'd23 - {1'b0, p});
    if (he == 5'd31) begin
      h2s = f32f16_pkg::Inf32 | ({22'd0, hf} << 13);
    end else if (he != 5'd0) begin
      h2s = {1'b0, 8'({3'd0, he} + 8'd112), hf, 13'd0};
    end else if (hf == 10'd0) begin
      h2s = '0;
    end else begin
      h2s = {1'b0, 8'({4'd0, p} + 8'd103), fsh[22:0]};
    end
    h2s[31] = value_i[15];
  end

  assign result_o = (func_i == f32f16_pkg::FUNC_H2S) ? h2s : {16'd0, half};

endmodule

@@ src/float32_float16_converter.sv @@
// Each accepted input word passes the input register, then the result register.
// Throughput: one word per cycle; input and result registers form a two-stage
// pipeline that advances whenever its result register is free or being read.
// Reset: rst_ni is asynchronous and active low; it clears both valid flags,
// while payload registers are left unreset.
module float32_float16_converter (
  input logic         clk_i,
  input logic         rst_ni,
  f32f16_in_if.sink   in_i,
  f32f16_out_if.source out_o
);

  // Input stage register.
  logic                 in_vld_q;
  f32f16_pkg::in_t      in_q;
  // Result stage register.
  logic                 out_vld_q;
  logic [31:0]          res_q;
  logic [31:0]          res_d;
  logic                 adv_out;
  logic                 adv_in;

  // The result register loads when empty or when its word is taken; the
  // input register then moves on, so a full pipeline still takes a word
  // every cycle while the downstream side keeps reading.
  assign adv_out    = !out_vld_q || out_o.ready;
  assign adv_in     = !in_vld_q || adv_out;
  assign in_i.ready = adv_in;

  f32f16_core u_core (
    .func_i   (in_q.func),
    .value_i  (in_q.value),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) in_vld_q <= in_i.valid;
      if (adv_out) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_i.valid) in_q <= in_i.data;
    if (adv_out && in_vld_q) res_q <= res_d;
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.data.result_bits = res_q;

endmodule

@@ verif/tb_pkg_unused.sv @@
`timescale 1ns / 100ps

// Shared helpers for the converter testbench: predicts the converted word for
// either direction using integer arithmetic only.
package conv_predict_pkg;

  // Multiply a non-negative finite binary32 pattern by 2^-112, nearest even.
  function automatic logic [31:0] scale_by_2m112(logic [31:0] x);
    logic [31:0] expo;
    logic [31:0] mant;
    logic [31:0] shift;
    logic [31:0] kept;
    logic [31:0] rem;
    logic [31:0] half;
    expo = x >> 23;
    mant = x & 32'h007F_FFFF;
    if (expo >= 113) return x - (32'd112 << 23);
    if (expo != 0) mant = mant | 32'h0080_0000;
    else expo = 1;
    shift = 113 - expo;
    if (shift >= 25) return 0;
    kept = mant >> shift;
    rem  = mant & ((32'd1 << shift) - 1);
    half = 32'd1 << (shift - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    return kept;
  endfunction

  function automatic logic [31:0] single_to_half_bits(logic [31:0] w);
    logic [31:0] sgn;
    logic [31:0] mag;
    logic [31:0] t;
    logic [15:0] h;
    sgn = w & f32f16_pkg::Sign32;
    mag = w ^ sgn;
    if (mag >= f32f16_pkg::Inf32) begin
      h = (mag > f32f16_pkg::Inf32) ? f32f16_pkg::HalfNan : f32f16_pkg::HalfInf;
    end else begin
      t = scale_by_2m112(mag & f32f16_pkg::KeepMask) + 32'h1000;
      if (t > f32f16_pkg::HalfInfAt) t = f32f16_pkg::HalfInfAt;
      h = t[28:13];
    end
    return {16'h0, h | sgn[31:16]};
  endfunction

  function automatic logic [31:0] half_to_single_bits(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  expo;
    logic [9:0]  frac;
    logic [31:0] r;
    int          p;
    sgn  = {h[15], 31'h0};
    expo = h[14:10];
    frac = h[9:0];
    if (expo == 5'h1F) begin
      r = f32f16_pkg::Inf32 | (32'(frac) << 13);
    end else if (expo != 0) begin
      r = ((32'(expo) + 112) << 23) | (32'(frac) << 13);
    end else if (frac == 0) begin
      r = 0;
    end else begin
      p = 9;
      while (!frac[p]) p--;
      r = ((32'(p) + 103) << 23) | ((32'(frac) << (23 - p)) & 32'h007F_FFFF);
    end
    return r | sgn;
  endfunction

  function automatic logic [31:0] convert_word(f32f16_pkg::in_t item);
    if (f32f16_pkg::func_e'(item.func) == f32f16_pkg::FUNC_S2H) begin
      return single_to_half_bits(item.value);
    end
    return half_to_single_bits(item.value[15:0]);
  endfunction
endpackage

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

// Top level of the converter testbench. Words are pushed into the input
// channel with random gaps; each accepted word is converted by the package
// predictor and its result is queued. A separate process takes each output
// word and compares it with the oldest queued result.
module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  f32f16_in_if  in_ch ();
  f32f16_out_if out_ch ();

  float32_float16_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Converted words still waiting for the block to deliver them.
  logic [31:0] pending_words[$];
  int          fail_count = 0;
  // When set, the receiver holds ready low for a long stretch.
  bit          hold_off = 1'b0;
  int          hold_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: the ready line is redrawn at each edge. A long hold-off is
  // counted here, in cycles, while the sender keeps offering words.
  initial begin : receiver
    int gap;
    gap = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        hold_cycles++;
        if (hold_cycles >= 60) begin
          hold_off = 1'b0;
          hold_cycles = 0;
        end
      end else if (gap > 0) begin
        out_ch.ready <= 1'b0;
        gap--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) gap = pick_gap();
      end
    end
  end

  // Result checker: samples at the edge where the word is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, out_ch.data.result_bits);
        fail_count++;
      end else begin
        if (out_ch.data.result_bits !== pending_words[0]) begin
          $display("%0t: result_bits mismatch, expected %h actual %h",
                   $time, pending_words[0], out_ch.data.result_bits);
          fail_count++;
        end
        void'(pending_words.pop_front());
      end
    end
  end

  // Offers one word and waits until it is taken; the prediction is queued at
  // the accepting edge. Valid stays high across back-to-back words.
  task automatic send_word(f32f16_pkg::func_e fn, logic [31:0] value,
                           bit allow_gap = 1'b1);
    f32f16_pkg::in_t item;
    int              gap;
    item.func  = fn;
    item.value = value;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_words.push_back(conv_predict_pkg::convert_word(item));
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Extremes and the named special cases for single to half.
  task automatic test_single_to_half_directed();
    send_word(f32f16_pkg::FUNC_S2H, 32'h0000_0000);
    send_word(f32f16_pkg::FUNC_S2H, 32'h8000_0000);
    send_word(f32f16_pkg::FUNC_S2H, 32'h7F80_0000);
    send_word(f32f16_pkg::FUNC_S2H, 32'hFF80_0000);
    send_word(f32f16_pkg::FUNC_S2H, 32'h7FC0_0000);
    send_word(f32f16_pkg::FUNC_S2H, 32'hFF80_0001);
    send_word(f32f16_pkg::FUNC_S2H, 32'h7F7F_FFFF);
    send_word(f32f16_pkg::FUNC_S2H, 32'h4780_0000);  // 65536 saturates to infinity
    send_word(f32f16_pkg::FUNC_S2H, 32'h477F_E000);  // largest half
    send_word(f32f16_pkg::FUNC_S2H, 32'h3380_0000);  // smallest half subnormal
    send_word(f32f16_pkg::FUNC_S2H, 32'h3300_0000);  // tiny: rounds up to the smallest subnormal
    send_word(f32f16_pkg::FUNC_S2H, 32'h0000_0001);
    send_word(f32f16_pkg::FUNC_S2H, 32'hFFFF_FFFF);
  endtask

  // Half to single, including upper bits that must be ignored.
  task automatic test_half_to_single_directed();
    send_word(f32f16_pkg::FUNC_H2S, 32'h0000_0000);
    send_word(f32f16_pkg::FUNC_H2S, 32'h0000_8000);
    send_word(f32f16_pkg::FUNC_H2S, 32'h0000_0001);
    send_word(f32f16_pkg::FUNC_H2S, 32'h0000_03FF);
    send_word(f32f16_pkg::FUNC_H2S, 32'h0000_7C00);
    send_word(f32f16_pkg::FUNC_H2S, 32'h0000_FC00);
    send_word(f32f16_pkg::FUNC_H2S, 32'h0000_7E01);  // NaN keeps its mantissa
    send_word(f32f16_pkg::FUNC_H2S, 32'h0000_7BFF);
    send_word(f32f16_pkg::FUNC_H2S, 32'hFFFF_3C00);  // upper bits ignored
    send_word(f32f16_pkg::FUNC_H2S, 32'hA5A5_FFFF);
  endtask

  // Random words, biased toward exponents near the half range.
  task automatic test_random_words(int count);
    logic [31:0] v;
    for (int i = 0; i < count; i++) begin
      v = $urandom();
      if ($urandom_range(0, 2) != 0) v[30:23] = 8'($urandom_range(96, 145));
      send_word(f32f16_pkg::func_e'($urandom_range(0, 1)), v);
    end
  endtask

  // Receiver stalls for a long stretch while words keep coming back to back.
  task automatic test_output_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++)
      send_word(f32f16_pkg::func_e'($urandom_range(0, 1)), $urandom(), 1'b0);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_to_half_directed();
    test_half_to_single_directed();
    test_random_words(800);
    test_output_backpressure();
    test_random_words(800);
    idle_input();
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[float32_float16_converter] OK");
    end else begin
      $display("[float32_float16_converter] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("[float32_float16_converter] ERROR");
    $finish;
  end
endmodule
